[design/rau_pkg.sv]
package rau_pkg;

	// result format limit, numerator range and denominator bound follow from it
	localparam int WIDTH = 32;

	// field width and width of exact cross products
	localparam int DW = 32;
	localparam int PW = 2 * DW;
	localparam int KW = $clog2(PW);

	localparam logic [PW-1:0] LIM    = PW'(1) << (WIDTH - 1);
	localparam logic [PW-1:0] LIM_M1 = LIM - PW'(1);

	localparam logic [2:0] CMD_NORM = 3'd0;
	localparam logic [2:0] CMD_ADD  = 3'd1;
	localparam logic [2:0] CMD_SUB  = 3'd2;
	localparam logic [2:0] CMD_MUL  = 3'd3;
	localparam logic [2:0] CMD_DIV  = 3'd4;
	localparam logic [2:0] CMD_NEG  = 3'd5;
	localparam logic [2:0] CMD_CMP  = 3'd6;

	localparam logic [1:0] STAT_OK   = 2'd0;
	localparam logic [1:0] STAT_ZERO = 2'd1;
	localparam logic [1:0] STAT_OVF  = 2'd2;

	// which cross product the shared multiplier forms
	localparam logic [1:0] MUL_X = 2'd0;
	localparam logic [1:0] MUL_Y = 2'd1;
	localparam logic [1:0] MUL_D = 2'd2;

	typedef enum logic [3:0] {
		S_IDLE,
		S_MUL0,
		S_MUL1,
		S_MUL2,
		S_COMB,
		S_GCD,
		S_DIV,
		S_FIN
	} state_t;

	typedef struct packed {
		logic [2:0]           command;
		logic signed [DW-1:0] a_num;
		logic signed [DW-1:0] a_den;
		logic signed [DW-1:0] b_num;
		logic signed [DW-1:0] b_den;
	} in_item_t;

	typedef struct packed {
		logic signed [DW-1:0] res_num;
		logic [DW-2:0]        res_den;
		logic                 is_less;
		logic                 is_equal;
		logic                 is_greater;
		logic [1:0]           status;
	} out_item_t;

	typedef struct packed {
		logic       load;
		logic       mul_en;
		logic [1:0] mul_sel;
		logic       comb;
		logic       gcd_step;
		logic       div_init;
		logic       div_step;
		logic       fin;
	} dp_ctl_t;

	typedef struct packed {
		logic err;
		logic is_cmp;
		logic gcd_done;
	} dp_sts_t;

endpackage

[design/rau_req_if.sv]
interface rau_req_if;
	import rau_pkg::*;

	logic     valid;
	logic     ready;
	in_item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

[design/rau_rsp_if.sv]
interface rau_rsp_if;
	import rau_pkg::*;

	logic      valid;
	logic      ready;
	out_item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

[design/rational_arithmetic_unit_top.sv]
// Rational arithmetic unit: takes a command and two fractions a_num/a_den and b_num/b_den
// on req and returns one item on rsp with the result reduced to lowest terms (sign in the
// numerator, positive denominator), or the less/equal/greater flags for compare. One item
// is worked at a time. An item with a zero denominator or divisor goes straight to the
// result. Any other item has its exact cross products formed one after another on the
// shared 32x32 multiplier; compare then finishes, and the rest run a binary gcd loop doing
// one subtract or shift a cycle (the number of steps depends on the operands), then
// restoring division of numerator and denominator by the gcd. The result sits in an output
// register, so a new item is accepted while the previous result waits to be taken.
module rational_arithmetic_unit_top (
	input  logic             clk,
	input  logic             arst_n,
	rau_req_if.sink          req,
	rau_rsp_if.source        rsp
);
	import rau_pkg::*;

	dp_ctl_t ctl;
	dp_sts_t sts;

	rau_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.in_ready  (req.ready),
		.out_valid (rsp.valid),
		.out_ready (rsp.ready),
		.sts       (sts),
		.ctl       (ctl)
	);

	rau_datapath u_dp (
		.clk      (clk),
		.in_data  (req.data),
		.ctl      (ctl),
		.sts      (sts),
		.out_data (rsp.data)
	);

endmodule

[design/rau_datapath.sv]
module rau_datapath (
	input  logic               clk,
	input  rau_pkg::in_item_t  in_data,
	input  rau_pkg::dp_ctl_t   ctl,
	output rau_pkg::dp_sts_t   sts,
	output rau_pkg::out_item_t out_data
);
	import rau_pkg::*;

	function automatic logic [DW-1:0] mag(input logic [DW-1:0] v);
		return v[DW-1] ? (~v + 1'b1) : v;
	endfunction

	// operands as sign and magnitude
	logic [2:0]    cmd_q;
	logic [DW-1:0] an_q, ad_q, bn_q, bd_q;
	logic          a_neg_q, b_neg_q, err_q;

	logic [PW-1:0] px_q, py_q, pd_q;

	logic [PW-1:0] rnum_q, rden_q;
	logic          rneg_q, less_q, eq_q;

	logic [PW-1:0] u_q, v_q;
	logic [KW-1:0] k_q;

	logic [PW-1:0] g_q;
	logic [PW-1:0] qn_q, qd_q, remn_q, remd_q;

	out_item_t out_q;

	// load decode
	logic need_b, ld_err, ld_a_neg, ld_b_neg;
	always_comb begin
		need_b = in_data.command == CMD_ADD || in_data.command == CMD_SUB ||
			in_data.command == CMD_MUL || in_data.command == CMD_DIV ||
			in_data.command == CMD_CMP;
		ld_err = in_data.a_den == '0 || (need_b && in_data.b_den == '0) ||
			(in_data.command == CMD_DIV && in_data.b_num == '0);
		ld_a_neg = (in_data.a_num[DW-1] ^ in_data.a_den[DW-1]) && in_data.a_num != '0;
		ld_b_neg = (in_data.b_num[DW-1] ^ in_data.b_den[DW-1]) && in_data.b_num != '0;
	end

	logic is_addsub, is_cmp, is_mul, is_div;
	assign is_addsub = cmd_q == CMD_ADD || cmd_q == CMD_SUB;
	assign is_cmp    = cmd_q == CMD_CMP;
	assign is_mul    = cmd_q == CMD_MUL;
	assign is_div    = cmd_q == CMD_DIV;

	// shared multiplier
	logic [DW-1:0] op_a, op_b;
	logic [PW-1:0] prod;
	always_comb begin
		unique case (ctl.mul_sel)
			MUL_X: begin
				op_a = an_q;
				if (is_addsub || is_cmp || is_div)
					op_b = bd_q;
				else if (is_mul)
					op_b = bn_q;
				else
					op_b = DW'(1);
			end
			MUL_Y: begin
				op_a = bn_q;
				op_b = ad_q;
			end
			default: begin
				op_a = ad_q;
				if (is_div)
					op_b = bn_q;
				else if (is_addsub || is_cmp || is_mul)
					op_b = bd_q;
				else
					op_b = DW'(1);
			end
		endcase
	end
	assign prod = op_a * op_b;

	// combine cross products into one unreduced fraction
	logic          sy;
	logic [PW-1:0] sum_xy, dif_xy, dif_yx, rnum;
	logic          rneg, cmp_less, cmp_eq;
	always_comb begin
		sy     = (b_neg_q ^ (cmd_q == CMD_SUB)) && py_q != '0;
		sum_xy = px_q + py_q;
		dif_xy = px_q - py_q;
		dif_yx = py_q - px_q;
		rnum   = px_q;
		rneg   = a_neg_q;
		if (is_addsub) begin
			priority if (a_neg_q == sy) begin
				rnum = sum_xy;
				rneg = a_neg_q;
			end else if (px_q >= py_q) begin
				rnum = dif_xy;
				rneg = a_neg_q;
			end else begin
				rnum = dif_yx;
				rneg = sy;
			end
		end else if (is_mul || is_div) begin
			rneg = a_neg_q ^ b_neg_q;
		end else if (cmd_q == CMD_NEG) begin
			rneg = !a_neg_q && an_q != '0;
		end
		if (a_neg_q != b_neg_q) begin
			cmp_less = a_neg_q;
			cmp_eq   = 1'b0;
		end else begin
			cmp_eq   = px_q == py_q;
			cmp_less = a_neg_q ? (px_q > py_q) : (px_q < py_q);
		end
	end

	// binary gcd step
	logic [PW-1:0] u_nx, v_nx;
	logic [KW-1:0] k_nx;
	always_comb begin
		u_nx = u_q;
		v_nx = v_q;
		k_nx = k_q;
		priority if (!u_q[0] && !v_q[0]) begin
			u_nx = u_q >> 1;
			v_nx = v_q >> 1;
			k_nx = k_q + 1'b1;
		end else if (!u_q[0]) begin
			u_nx = u_q >> 1;
		end else if (!v_q[0]) begin
			v_nx = v_q >> 1;
		end else if (u_q >= v_q) begin
			u_nx = (u_q - v_q) >> 1;
		end else begin
			v_nx = (v_q - u_q) >> 1;
		end
	end

	logic [PW-1:0] gbase;
	assign gbase = (u_q == '0) ? v_q : u_q;

	// two restoring dividers sharing the divisor
	logic [PW:0]   tn, td, gx;
	logic          bn_bit, bd_bit;
	logic [PW-1:0] remn_nx, remd_nx;
	always_comb begin
		gx      = {1'b0, g_q};
		tn      = {remn_q, qn_q[PW-1]};
		td      = {remd_q, qd_q[PW-1]};
		bn_bit  = tn >= gx;
		bd_bit  = td >= gx;
		remn_nx = bn_bit ? PW'(tn - gx) : tn[PW-1:0];
		remd_nx = bd_bit ? PW'(td - gx) : td[PW-1:0];
	end

	// result format check
	out_item_t fin_item;
	logic      qn_neg, ovf;
	always_comb begin
		fin_item = '0;
		qn_neg   = rneg_q && qn_q != '0;
		ovf      = qd_q > LIM_M1 || qn_q > (qn_neg ? LIM : LIM_M1);
		if (err_q) begin
			fin_item.status = STAT_ZERO;
		end else if (is_cmp) begin
			fin_item.is_less    = less_q;
			fin_item.is_equal   = eq_q;
			fin_item.is_greater = !less_q && !eq_q;
			fin_item.status     = STAT_OK;
		end else if (ovf) begin
			fin_item.status = STAT_OVF;
		end else begin
			fin_item.res_num = qn_neg ? (~qn_q[DW-1:0] + 1'b1) : qn_q[DW-1:0];
			fin_item.res_den = qd_q[DW-2:0];
			fin_item.status  = STAT_OK;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			cmd_q   <= in_data.command;
			an_q    <= mag(in_data.a_num);
			ad_q    <= mag(in_data.a_den);
			bn_q    <= mag(in_data.b_num);
			bd_q    <= mag(in_data.b_den);
			a_neg_q <= ld_a_neg;
			b_neg_q <= ld_b_neg;
			err_q   <= ld_err;
		end
		if (ctl.mul_en) begin
			unique case (ctl.mul_sel)
				MUL_X:   px_q <= prod;
				MUL_Y:   py_q <= prod;
				default: pd_q <= prod;
			endcase
		end
		if (ctl.comb) begin
			rnum_q <= rnum;
			rden_q <= pd_q;
			rneg_q <= rneg;
			less_q <= cmp_less;
			eq_q   <= cmp_eq;
			u_q    <= rnum;
			v_q    <= pd_q;
			k_q    <= '0;
		end
		if (ctl.gcd_step) begin
			u_q <= u_nx;
			v_q <= v_nx;
			k_q <= k_nx;
		end
		if (ctl.div_init) begin
			g_q    <= gbase << k_q;
			qn_q   <= rnum_q;
			qd_q   <= rden_q;
			remn_q <= '0;
			remd_q <= '0;
		end
		if (ctl.div_step) begin
			remn_q <= remn_nx;
			remd_q <= remd_nx;
			qn_q   <= {qn_q[PW-2:0], bn_bit};
			qd_q   <= {qd_q[PW-2:0], bd_bit};
		end
		if (ctl.fin)
			out_q <= fin_item;
	end

	assign sts.err      = err_q;
	assign sts.is_cmp   = is_cmp;
	assign sts.gcd_done = u_q == '0 || v_q == '0;
	assign out_data     = out_q;

endmodule

[design/rau_ctrl.sv]
module rau_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	output logic             out_valid,
	input  logic             out_ready,
	input  rau_pkg::dp_sts_t sts,
	output rau_pkg::dp_ctl_t ctl
);
	import rau_pkg::*;

	state_t        state_q, state_d;
	logic [KW-1:0] cnt_q;
	logic          out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= (state_q == S_DIV) ? cnt_q + 1'b1 : '0;
			if (ctl.fin)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	always_comb begin
		state_d  = state_q;
		ctl      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					ctl.load = 1'b1;
					state_d  = S_MUL0;
				end
			end
			S_MUL0: begin
				if (sts.err) begin
					state_d = S_FIN;
				end else begin
					ctl.mul_en  = 1'b1;
					ctl.mul_sel = MUL_X;
					state_d     = S_MUL1;
				end
			end
			S_MUL1: begin
				ctl.mul_en  = 1'b1;
				ctl.mul_sel = MUL_Y;
				state_d     = S_MUL2;
			end
			S_MUL2: begin
				ctl.mul_en  = 1'b1;
				ctl.mul_sel = MUL_D;
				state_d     = S_COMB;
			end
			S_COMB: begin
				ctl.comb = 1'b1;
				state_d  = sts.is_cmp ? S_FIN : S_GCD;
			end
			S_GCD: begin
				if (sts.gcd_done) begin
					ctl.div_init = 1'b1;
					state_d      = S_DIV;
				end else begin
					ctl.gcd_step = 1'b1;
				end
			end
			S_DIV: begin
				ctl.div_step = 1'b1;
				if (cnt_q == '1)
					state_d = S_FIN;
			end
			S_FIN: begin
				if (!out_valid_q || out_ready) begin
					ctl.fin = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	assign out_valid = out_valid_q;

`ifndef SYNTH
	a_fin_slot_free: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.fin |-> (!out_valid_q || out_ready))
		else $error("result written over an item not yet taken");
	a_div_starts_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_GCD && sts.gcd_done) |=> (state_q == S_DIV && cnt_q == '0))
		else $error("divide sequence did not start from step zero");
	a_err_skips_work: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_MUL0 && sts.err) |=> (state_q == S_FIN))
		else $error("zero denominator item went through the datapath");
	a_valid_from_fin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(ctl.fin))
		else $error("result valid raised without a finished item");
`endif

endmodule

[test/tb_top.sv]
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import rau_pkg::*;

	localparam logic [2:0] CMD_SPARE = 3'd7;

	localparam int RAND_PER_PHASE = 206;
	localparam int LONG_HOLD      = 600;
	localparam int TAIL_CYCLES    = 250;
	localparam int CYCLE_LIMIT    = 1000000;

	typedef struct {
		logic [2:0]  op;
		logic [31:0] an;
		logic [31:0] ad;
		logic [31:0] bn;
		logic [31:0] bd;
		bit          typed;
		logic [31:0] e_num;
		logic [30:0] e_den;
		logic [2:0]  e_flags; // less, equal, greater
		logic [1:0]  e_st;
	} dir_row_t;

	typedef struct {
		bit          neg;
		logic [63:0] n;
		logic [63:0] d;
	} ratio_t;

	// directed items, expected result typed in where it is obvious
	dir_row_t dir_tab [25] = '{
		'{CMD_NORM,  32'h0000_0000, 32'hFFFF_FFFB, 32'h0, 32'h1, 1'b1,
			32'h0000_0000, 31'd1, 3'b000, STAT_OK},
		'{CMD_NORM,  32'h0000_0006, 32'hFFFF_FFFC, 32'h0, 32'h1, 1'b1,
			32'hFFFF_FFFD, 31'd2, 3'b000, STAT_OK},
		'{CMD_NORM,  32'h0000_0005, 32'h0000_0000, 32'h0, 32'h1, 1'b1,
			32'h0, 31'd0, 3'b000, STAT_ZERO},
		'{CMD_ADD,   32'h0000_0001, 32'h0000_0002, 32'h1, 32'h0, 1'b1,
			32'h0, 31'd0, 3'b000, STAT_ZERO},
		'{CMD_DIV,   32'h0000_0001, 32'h0000_0002, 32'h0, 32'h3, 1'b1,
			32'h0, 31'd0, 3'b000, STAT_ZERO},
		'{CMD_NORM,  32'h8000_0000, 32'hFFFF_FFFF, 32'h0, 32'h1, 1'b1,
			32'h0, 31'd0, 3'b000, STAT_OVF},
		'{CMD_NORM,  32'h8000_0000, 32'h0000_0001, 32'h0, 32'h1, 1'b1,
			32'h8000_0000, 31'd1, 3'b000, STAT_OK},
		'{CMD_NEG,   32'h8000_0000, 32'h0000_0001, 32'h0, 32'h1, 1'b1,
			32'h0, 31'd0, 3'b000, STAT_OVF},
		'{CMD_NORM,  32'h0000_0001, 32'h8000_0000, 32'h0, 32'h1, 1'b1,
			32'h0, 31'd0, 3'b000, STAT_OVF},
		'{CMD_NORM,  32'h0000_0002, 32'h8000_0000, 32'h0, 32'h1, 1'b1,
			32'hFFFF_FFFF, 31'h4000_0000, 3'b000, STAT_OK},
		'{CMD_MUL,   32'h7FFF_FFFF, 32'h0000_0001, 32'h7FFF_FFFF, 32'h1, 1'b1,
			32'h0, 31'd0, 3'b000, STAT_OVF},
		'{CMD_CMP,   32'h0000_0001, 32'h0000_0002, 32'h2, 32'h4, 1'b1,
			32'h0, 31'd0, 3'b010, STAT_OK},
		'{CMD_CMP,   32'hFFFF_FFFF, 32'h0000_0003, 32'h1, 32'h3, 1'b1,
			32'h0, 31'd0, 3'b100, STAT_OK},
		'{CMD_CMP,   32'h0000_0000, 32'h0000_0001, 32'h1, 32'hFFFF_FFF9, 1'b1,
			32'h0, 31'd0, 3'b001, STAT_OK},
		'{CMD_CMP,   32'h0000_0001, 32'h0000_0002, 32'h1, 32'h0, 1'b1,
			32'h0, 31'd0, 3'b000, STAT_ZERO},
		'{CMD_SPARE, 32'h0000_0004, 32'h0000_0008, 32'h0, 32'h0, 1'b1,
			32'h0000_0001, 31'd2, 3'b000, STAT_OK},
		'{CMD_ADD,   32'h0000_0001, 32'h0000_0003, 32'h1, 32'h6, 1'b1,
			32'h0000_0001, 31'd2, 3'b000, STAT_OK},
		'{CMD_SUB,   32'h0000_0001, 32'h0000_0002, 32'h1, 32'h2, 1'b1,
			32'h0000_0000, 31'd1, 3'b000, STAT_OK},
		'{CMD_SUB,   32'h8000_0000, 32'h0000_0001, 32'h7FFF_FFFF, 32'h1, 1'b0,
			32'h0, 31'd0, 3'b000, STAT_OK},
		'{CMD_MUL,   32'hFFFF_FFFD, 32'h0000_0004, 32'h8, 32'hFFFF_FFF7, 1'b0,
			32'h0, 31'd0, 3'b000, STAT_OK},
		'{CMD_DIV,   32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0,
			32'h0, 31'd0, 3'b000, STAT_OK},
		'{CMD_NEG,   32'h0000_0003, 32'hFFFF_FFFC, 32'h0, 32'h0, 1'b0,
			32'h0, 31'd0, 3'b000, STAT_OK},
		'{CMD_ADD,   32'h7FFF_FFFF, 32'h7FFF_FFFE, 32'h8000_0001, 32'h7FFF_FFFF, 1'b0,
			32'h0, 31'd0, 3'b000, STAT_OK},
		'{CMD_CMP,   32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFE, 1'b0,
			32'h0, 31'd0, 3'b000, STAT_OK},
		'{CMD_DIV,   32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h8000_0000, 32'h8000_0000, 1'b0,
			32'h0, 31'd0, 3'b000, STAT_OK}
	};

	int idle_send_tab [4] = '{0, 53, 0, 27};
	int stall_tab [4]     = '{0, 0, 53, 27};

	logic clk;
	logic arst_n;

	rau_req_if req_if ();
	rau_rsp_if rsp_if ();

	rational_arithmetic_unit_top u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_if),
		.rsp    (rsp_if)
	);

	out_item_t pending_results [$];
	int        errors = 0;
	int        send_idle_pct = 0;
	int        rsp_stall_pct = 0;
	bit        hold_pending = 1'b0;
	int        cycle_cnt = 0;

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	function automatic ratio_t split_ratio(logic [31:0] num, logic [31:0] den);
		ratio_t      r;
		logic [31:0] t;
		r.neg = num[31] ^ den[31];
		t = num[31] ? -num : num;
		r.n = {32'd0, t};
		t = den[31] ? -den : den;
		r.d = {32'd0, t};
		if (r.n == 0)
			r.neg = 1'b0;
		return r;
	endfunction

	function automatic logic [63:0] euclid_gcd(logic [63:0] x, logic [63:0] y);
		while (x != 0 && y != 0) begin
			if (x < y)
				y = y % x;
			else
				x = x % y;
		end
		return (x == 0) ? y : x;
	endfunction

	// exact result of one item: sign/magnitude with 64-bit magnitudes
	function automatic out_item_t rational_result(in_item_t it);
		out_item_t   res;
		ratio_t      a;
		ratio_t      b;
		ratio_t      r;
		logic [63:0] x;
		logic [63:0] y;
		logic [63:0] g;
		logic [63:0] t;
		bit          sy;
		bit          less;
		bit          eq;
		logic [2:0]  op;
		res = '0;
		op = it.command;
		a = split_ratio(it.a_num, it.a_den);
		b = split_ratio(it.b_num, it.b_den);
		if (a.d == 0 || (op != CMD_NORM && op != CMD_NEG && op != CMD_SPARE && b.d == 0) ||
				(op == CMD_DIV && b.n == 0)) begin
			res.status = STAT_ZERO;
			return res;
		end
		r = a;
		x = a.n * b.d;
		y = b.n * a.d;
		case (op)
			CMD_ADD, CMD_SUB: begin
				sy = (b.neg != (op == CMD_SUB)) && y != 0;
				if (a.neg == sy) begin
					r.n = x + y;
				end else if (x >= y) begin
					r.n = x - y;
				end else begin
					r.n = y - x;
					r.neg = sy;
				end
				r.d = a.d * b.d;
			end
			CMD_MUL: begin
				r.n = a.n * b.n;
				r.d = a.d * b.d;
				r.neg = a.neg != b.neg;
			end
			CMD_DIV: begin
				r.n = x;
				r.d = a.d * b.n;
				r.neg = a.neg != b.neg;
			end
			CMD_NEG: begin
				r.neg = !a.neg && a.n != 0;
			end
			CMD_CMP: begin
				if (a.neg != b.neg) begin
					less = a.neg;
					eq = 1'b0;
				end else begin
					eq = (x == y);
					less = a.neg ? (x > y) : (x < y);
				end
				res.is_less = less;
				res.is_equal = eq;
				res.is_greater = !less && !eq;
				res.status = STAT_OK;
				return res;
			end
			default: begin
			end
		endcase
		g = euclid_gcd(r.n, r.d);
		if (g == 0) begin
			res.status = STAT_ZERO;
			return res;
		end
		r.n = r.n / g;
		r.d = r.d / g;
		if (r.n == 0)
			r.neg = 1'b0;
		if (r.d > LIM_M1 || r.n > (r.neg ? LIM : LIM_M1)) begin
			res.status = STAT_OVF;
			return res;
		end
		t = r.neg ? -r.n : r.n;
		res.res_num = t[31:0];
		res.res_den = r.d[30:0];
		res.status = STAT_OK;
		return res;
	endfunction

	function automatic logic [31:0] rand_operand();
		int s;
		case ($urandom_range(9))
			0, 1, 2, 3: begin
				s = $urandom_range(40);
				return 32'(s - 20);
			end
			4, 5: begin
				s = $urandom_range(65535);
				return 32'(s - 32768);
			end
			6, 7: return $urandom();
			8: begin
				case ($urandom_range(5))
					0: return 32'h8000_0000;
					1: return 32'h7FFF_FFFF;
					2: return 32'hFFFF_FFFF;
					3: return 32'h8000_0001;
					4: return 32'h4000_0000;
					default: return 32'h0000_0001;
				endcase
			end
			default: begin
				s = $urandom_range(200);
				return 32'((s - 100) * int'($urandom_range(1, 1000)));
			end
		endcase
	endfunction

	// common factor on both parts so that reduction has work to do
	function automatic void scale_pair(inout logic [31:0] num, inout logic [31:0] den);
		int k;
		if ($urandom_range(2) != 0)
			return;
		k = $urandom_range(2, 60);
		if ($signed(num) > -65536 && $signed(num) < 65536 &&
				$signed(den) > -65536 && $signed(den) < 65536) begin
			num = 32'($signed(num) * k);
			den = 32'($signed(den) * k);
		end
	endfunction

	function automatic in_item_t rand_item();
		in_item_t it;
		logic [31:0] an;
		logic [31:0] ad;
		logic [31:0] bn;
		logic [31:0] bd;
		it.command = 3'($urandom_range(7));
		an = rand_operand();
		ad = rand_operand();
		bn = rand_operand();
		bd = ($urandom_range(15) == 0) ? 32'd1 : rand_operand();
		scale_pair(an, ad);
		scale_pair(bn, bd);
		it.a_num = an;
		it.a_den = ad;
		it.b_num = bn;
		it.b_den = bd;
		return it;
	endfunction

	task automatic push_operands(input in_item_t it, input out_item_t want);
		while ($urandom_range(99) < send_idle_pct) begin
			req_if.valid <= 1'b0;
			@(posedge clk);
		end
		req_if.valid <= 1'b1;
		req_if.data <= it;
		do
			@(posedge clk);
		while (req_if.ready !== 1'b1);
		pending_results.push_back(want);
	endtask

	task automatic check_field(input string name, input logic [63:0] want,
			input logic [63:0] got);
		if (got !== want) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			errors++;
		end
	endtask

	// result monitor
	always @(posedge clk) begin
		out_item_t want;
		out_item_t got;
		if (arst_n === 1'b1 && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
			got = rsp_if.data;
			if (pending_results.size() == 0) begin
				$error("result with nothing pending: %0h", got);
				errors++;
			end else begin
				want = pending_results.pop_front();
				check_field("res_num", 64'(want.res_num), 64'(got.res_num));
				check_field("res_den", 64'(want.res_den), 64'(got.res_den));
				check_field("is_less", 64'(want.is_less), 64'(got.is_less));
				check_field("is_equal", 64'(want.is_equal), 64'(got.is_equal));
				check_field("is_greater", 64'(want.is_greater), 64'(got.is_greater));
				check_field("status", 64'(want.status), 64'(got.status));
			end
		end
	end

	// result side ready, with one long hold-off on request
	initial begin
		rsp_if.ready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (hold_pending) begin
				hold_pending = 1'b0;
				rsp_if.ready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
			end
			rsp_if.ready <= ($urandom_range(99) >= rsp_stall_pct);
		end
	end

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt == CYCLE_LIMIT) begin
			$display("tb_top: errors");
			$finish;
		end
	end

	initial begin
		in_item_t  it;
		out_item_t want;
		arst_n <= 1'b0;
		req_if.valid <= 1'b0;
		req_if.data <= '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_tab[i]) begin
			it.command = dir_tab[i].op;
			it.a_num = dir_tab[i].an;
			it.a_den = dir_tab[i].ad;
			it.b_num = dir_tab[i].bn;
			it.b_den = dir_tab[i].bd;
			if (dir_tab[i].typed) begin
				want.res_num = dir_tab[i].e_num;
				want.res_den = dir_tab[i].e_den;
				{want.is_less, want.is_equal, want.is_greater} = dir_tab[i].e_flags;
				want.status = dir_tab[i].e_st;
			end else begin
				want = rational_result(it);
			end
			push_operands(it, want);
		end

		for (int ph = 0; ph < 4; ph++) begin
			send_idle_pct = idle_send_tab[ph];
			rsp_stall_pct = stall_tab[ph];
			for (int i = 0; i < RAND_PER_PHASE; i++) begin
				// receiver holds off while items keep coming, input backs up
				if (ph == 0 && i == 40)
					hold_pending = 1'b1;
				it = rand_item();
				push_operands(it, rational_result(it));
			end
			if (ph == 1) begin
				req_if.valid <= 1'b0;
				while (pending_results.size() != 0)
					@(posedge clk);
			end
		end

		req_if.valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("tb_top: clean");
		else
			$display("tb_top: errors");
		$finish;
	end

endmodule
